// ===== rtl/jac_pkg.sv =====
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants of the joystick axis auto-calibration unit.
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int STICKS         = 4;
    localparam int AXES_PER_STICK = 8;
    localparam int SAMPLE_BITS    = 16;

    localparam int STICK_BITS = $clog2(STICKS);
    localparam int AXIS_BITS  = $clog2(AXES_PER_STICK);
    localparam int CAL_DEPTH  = STICKS * AXES_PER_STICK;
    localparam int SLOT_BITS  = $clog2(CAL_DEPTH);
    localparam int WIDE_BITS  = SAMPLE_BITS + 2;

    localparam int ANALOG_SCALE = 128;
    localparam int QUO_BITS     = $clog2(ANALOG_SCALE) + 1;
    localparam int STEP_BITS    = $clog2(QUO_BITS);
    localparam int ANALOG_BITS  = QUO_BITS + 1;

    localparam int CFG_AXES_BITS  = 4;
    localparam int ANALOG_MIN_AXES = 2;
    localparam int ANALOG_LAST_AXIS = 1;
    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;
    localparam int REG_IDX_LSB    = 2;

    localparam logic REG_AXES_IN_USE   = 1'b0;
    localparam logic REG_ANALOG_ENABLE = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] MIN_RESET = SAMPLE_BITS'(-10);
    localparam logic signed [SAMPLE_BITS-1:0] MAX_RESET = SAMPLE_BITS'(10);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic signed [SAMPLE_BITS-1:0] maximum;
    } cal_entry_t;

    localparam cal_entry_t CAL_RESET_ENTRY = '{minimum: MIN_RESET, maximum: MAX_RESET};

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        cal_entry_t           entry;
    } cal_wr_t;

    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] dividend;
        logic [SAMPLE_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [QUO_BITS-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EVAL,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/jac_if.sv =====
// ----------------------------------------------------------------------------
// jac_in_if / jac_out_if
// Valid/ready channels for axis samples and evaluation results.
// ----------------------------------------------------------------------------
interface jac_in_if import jac_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [STICK_BITS-1:0]         stick_index;
    logic [AXIS_BITS-1:0]          axis_index;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic signed [SAMPLE_BITS-1:0] rest_value;

    modport source (
        output valid, stick_index, axis_index, sample_value, rest_value,
        input  ready
    );
    modport sink (
        input  valid, stick_index, axis_index, sample_value, rest_value,
        output ready
    );
endinterface

interface jac_out_if import jac_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          dir_negative;
    logic                          dir_positive;
    logic signed [ANALOG_BITS-1:0] analog_value;
    logic                          analog_valid;

    modport source (
        output valid, dir_negative, dir_positive, analog_value, analog_valid,
        input  ready
    );
    modport sink (
        input  valid, dir_negative, dir_positive, analog_value, analog_valid,
        output ready
    );
endinterface

// ===== rtl/joystick_axis_autocalibrate_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_autocalibrate_unit
// Per-axis auto-calibration with direction flags and scaled analog output.
// ----------------------------------------------------------------------------
// One sample is processed at a time. A sample of an axis in use passes from
// acceptance to the result register through memory read, min/max update and
// write-back, threshold evaluation and result load, with a division before the
// result load when the analog value is computed, done by the bit-serial
// divider that produces one quotient bit per cycle; a sample of an axis not
// in use goes straight to the result load. The next sample is accepted in the
// cycle after the result is loaded, even while that result still waits to be
// taken. The calibration bounds are held in a 32-entry memory whose entries
// read as -10/10 until first written; reset needs no clearing pass.
// ----------------------------------------------------------------------------
module joystick_axis_autocalibrate_unit
    import jac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    jac_in_if.sink                sample_ch,
    jac_out_if.source             result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    state_t state_reg;
    state_t state_next;

    logic [CFG_AXES_BITS-1:0] axes_in_use_reg;
    logic [CFG_AXES_BITS-1:0] axes_in_use_next;
    logic                     analog_enable_reg;
    logic                     analog_enable_next;

    logic [STICK_BITS-1:0]         stick_reg;
    logic [AXIS_BITS-1:0]          axis_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] rest_reg;
    logic                          in_range_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic                          neg_reg;
    logic                          pos_reg;
    logic                          analog_reg;
    logic                          below_reg;
    logic                          den_zero_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_neg_reg;
    logic                          out_pos_reg;
    logic signed [ANALOG_BITS-1:0] out_value_reg;
    logic                          out_avalid_reg;

    logic       accept;
    logic       cfg_write;
    logic       in_range;
    logic       analog_app;
    logic       load_out;
    logic       upd_en;
    logic       eval_en;
    cal_entry_t cal_rd;
    cal_entry_t cal_new;
    cal_wr_t    cal_wr;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    logic signed [WIDE_BITS-1:0] val_w;
    logic signed [WIDE_BITS-1:0] ctr_w;
    logic signed [WIDE_BITS-1:0] span_w;
    logic signed [WIDE_BITS-1:0] thr_w;
    logic signed [WIDE_BITS-1:0] low_span_w;
    logic signed [WIDE_BITS-1:0] dev_w;
    logic                        above;
    logic                        eval_neg;
    logic                        eval_pos;
    logic [SAMPLE_BITS-1:0]      mag;
    logic [SAMPLE_BITS-1:0]      den;
    logic signed [ANALOG_BITS-1:0] quo_s;
    logic signed [ANALOG_BITS-1:0] analog_res;
    logic [SLOT_BITS-1:0]        rd_slot;
    logic [SLOT_BITS-1:0]        item_slot;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        axes_in_use_next   = axes_in_use_reg;
        analog_enable_next = analog_enable_reg;
        if (cfg_write)
        begin
            case (paddr[REG_IDX_LSB])
                REG_AXES_IN_USE:   axes_in_use_next   = pwdata[CFG_AXES_BITS-1:0];
                REG_ANALOG_ENABLE: analog_enable_next = pwdata[0];
                default:           axes_in_use_next   = axes_in_use_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_IDX_LSB])
            REG_AXES_IN_USE:   prdata = PDATA_BITS'(axes_in_use_reg);
            REG_ANALOG_ENABLE: prdata = PDATA_BITS'(analog_enable_reg);
            default:           prdata = '0;
        endcase
    end

    // transaction acceptance and slot selection
    assign accept   = sample_ch.valid && sample_ch.ready;
    assign in_range = (32'(sample_ch.stick_index) < STICKS)
                   && (32'(sample_ch.axis_index) < AXES_PER_STICK)
                   && (CFG_AXES_BITS'(sample_ch.axis_index) < axes_in_use_reg);
    assign rd_slot   = SLOT_BITS'(32'(sample_ch.stick_index) * AXES_PER_STICK
                     + 32'(sample_ch.axis_index));
    assign item_slot = SLOT_BITS'(32'(stick_reg) * AXES_PER_STICK + 32'(axis_reg));

    assign analog_app = analog_enable_reg
                     && (32'(axes_in_use_reg) >= ANALOG_MIN_AXES)
                     && (32'(axis_reg) <= ANALOG_LAST_AXIS);

    jac_cal_ram u_cal_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_slot),
        .wr      (cal_wr),
        .rd_data (cal_rd)
    );

    // min/max update
    always_comb
    begin
        cal_new = cal_rd;
        if (sample_reg > cal_rd.maximum)
        begin
            cal_new.maximum = sample_reg;
        end
        else if (sample_reg < cal_rd.minimum)
        begin
            cal_new.minimum = sample_reg;
        end
    end

    assign cal_wr.en    = upd_en;
    assign cal_wr.addr  = item_slot;
    assign cal_wr.entry = cal_new;

    // threshold and divider operands
    assign val_w      = WIDE_BITS'(sample_reg);
    assign ctr_w      = WIDE_BITS'(rest_reg);
    assign span_w     = WIDE_BITS'(max_reg) - ctr_w;
    assign thr_w      = span_w >>> 1;
    assign low_span_w = ctr_w - WIDE_BITS'(min_reg);
    assign dev_w      = val_w - ctr_w;
    assign above      = val_w > ctr_w;
    assign eval_neg   = val_w < (ctr_w - thr_w);
    assign eval_pos   = !eval_neg && (val_w > (ctr_w + thr_w));
    assign mag        = above ? dev_w[SAMPLE_BITS-1:0] : SAMPLE_BITS'(-dev_w);
    assign den        = above ? span_w[SAMPLE_BITS-1:0] : low_span_w[SAMPLE_BITS-1:0];

    assign div_req.start    = eval_en && analog_app;
    assign div_req.dividend = mag;
    assign div_req.divisor  = den;

    jac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign quo_s = $signed({1'b0, div_rsp.quotient});

    always_comb
    begin
        analog_res = '0;
        if (in_range_reg && analog_reg && !den_zero_reg)
        begin
            analog_res = below_reg ? -quo_s : quo_s;
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? ST_UPDATE : ST_FINISH;
                end
            end
            ST_UPDATE: state_next = ST_EVAL;
            ST_EVAL:   state_next = analog_app ? ST_DIVIDE : ST_FINISH;
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        sample_ch.ready = 1'b0;
        upd_en          = 1'b0;
        eval_en         = 1'b0;
        load_out        = 1'b0;
        case (state_reg)
            ST_IDLE:   sample_ch.ready = 1'b1;
            ST_UPDATE: upd_en          = 1'b1;
            ST_EVAL:   eval_en         = 1'b1;
            ST_DIVIDE: load_out        = 1'b0;
            ST_FINISH: load_out        = !out_valid_reg || result_ch.ready;
            default:   load_out        = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stick_reg    <= sample_ch.stick_index;
            axis_reg     <= sample_ch.axis_index;
            sample_reg   <= sample_ch.sample_value;
            rest_reg     <= sample_ch.rest_value;
            in_range_reg <= in_range;
        end
        if (upd_en)
        begin
            max_reg <= cal_new.maximum;
            min_reg <= cal_new.minimum;
        end
        if (eval_en)
        begin
            neg_reg      <= eval_neg;
            pos_reg      <= eval_pos;
            analog_reg   <= analog_app;
            below_reg    <= val_w < ctr_w;
            den_zero_reg <= den == '0;
        end
        if (load_out)
        begin
            out_neg_reg    <= in_range_reg && neg_reg;
            out_pos_reg    <= in_range_reg && pos_reg;
            out_value_reg  <= analog_res;
            out_avalid_reg <= in_range_reg && analog_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            axes_in_use_reg   <= '0;
            analog_enable_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            axes_in_use_reg   <= axes_in_use_next;
            analog_enable_reg <= analog_enable_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.dir_negative = out_neg_reg;
    assign result_ch.dir_positive = out_pos_reg;
    assign result_ch.analog_value = out_value_reg;
    assign result_ch.analog_valid = out_avalid_reg;

    // calibration bounds never cross
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        upd_en |-> cal_rd.minimum <= cal_rd.maximum)
        else $error("calibration minimum above maximum");

    // divider is only started when idle
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // memory written only in the update step
    a_wr_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        cal_wr.en |-> state_reg == ST_UPDATE)
        else $error("calibration write outside update");

    // a loaded result has exclusive flags and no stray analog value
    a_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> !(out_neg_reg && out_pos_reg)
                     && (out_avalid_reg || out_value_reg == '0))
        else $error("inconsistent result fields");

endmodule

// ===== rtl/jac_cal_ram.sv =====
// ----------------------------------------------------------------------------
// jac_cal_ram
// Calibration store: per-axis minimum and maximum, one read and one write
// port, registered read data, per-entry valid bits for the reset value.
// ----------------------------------------------------------------------------
module jac_cal_ram
    import jac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [SLOT_BITS-1:0] rd_addr,
    input  cal_wr_t              wr,
    output cal_entry_t           rd_data
);

    cal_entry_t mem [CAL_DEPTH];

    cal_entry_t           rd_word_reg;
    logic                 rd_valid_reg;
    logic                 rd_valid_next;
    logic [CAL_DEPTH-1:0] valid_reg;
    logic [CAL_DEPTH-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
        if (rd_en)
        begin
            rd_valid_next = valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // never-written entries read as the reset bounds
    assign rd_data = rd_valid_reg ? rd_word_reg : CAL_RESET_ENTRY;

endmodule

// ===== rtl/jac_div.sv =====
// ----------------------------------------------------------------------------
// jac_div
// Restoring divider for the scaled deflection: one quotient bit per cycle,
// quotient = floor(dividend * 128 / divisor) for dividend <= divisor.
// ----------------------------------------------------------------------------
module jac_div
    import jac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [SAMPLE_BITS:0]   rem_reg;
    logic [SAMPLE_BITS:0]   rem_next;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic [SAMPLE_BITS-1:0] den_next;
    logic [QUO_BITS-1:0]    quo_reg;
    logic [QUO_BITS-1:0]    quo_next;
    logic [STEP_BITS-1:0]   step_reg;
    logic [STEP_BITS-1:0]   step_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;

    logic                   ge;
    logic [SAMPLE_BITS:0]   diff;

    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, req.dividend};
            den_next  = req.divisor;
            quo_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the shift cannot overflow
            rem_next = {diff[SAMPLE_BITS-1:0], 1'b0};
            quo_next = {quo_reg[QUO_BITS-2:0], ge};
            if (step_reg == STEP_BITS'(QUO_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
